// ----- rtl/core/nget_pkg.sv -----
// Shared types and constants for the next greater element table.
// Used by nget_table and next_greater_element_table_top; depends on nothing.
`default_nettype none

package nget_pkg;

  // Command codes carried on the cmd field.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Status codes reported with every result word.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_STACK_FULL = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  // Value returned by a query that finds no entry.
  localparam logic [31:0] NONE_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH,
    S_RESULT
  } state_t;

  // Requests from the control sequencer to the table.
  typedef struct packed {
    logic        clear;
    logic        wr_en;
    logic [31:0] key;
    logic [31:0] greater;
    logic        q_start;
    logic [31:0] q_key;
  } tbl_req_t;

  // Status returned by the table.
  typedef struct packed {
    logic        full;
    logic        q_done;
    logic        q_found;
    logic [31:0] q_greater;
  } tbl_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/nget_table.sv -----
// Pair table of the next greater element block: memory, fill count and search.
// Depends on nget_pkg for the request and response structs.
`default_nettype none

module nget_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nget_pkg::tbl_req_t req,
  output nget_pkg::tbl_rsp_t     rsp
);
  import nget_pkg::*;

  localparam int TCW = $clog2(TABLE_DEPTH + 1);
  localparam int TAW = $clog2(TABLE_DEPTH);

  logic [63:0]    tbl_mem [TABLE_DEPTH];
  logic [63:0]    rd_data;
  logic [TAW-1:0] rd_addr;
  logic [TCW-1:0] count;
  logic [TCW-1:0] q_rem;
  logic [TCW-1:0] q_rem_dec;
  logic           q_busy;
  logic           q_pend;
  logic [31:0]    q_key;
  logic           q_issue;
  logic           q_hit;
  logic           q_miss;
  logic           full;

  assign full      = (count == TCW'(TABLE_DEPTH));
  assign q_rem_dec = q_rem - TCW'(1);
  assign rd_addr   = q_rem_dec[TAW-1:0];
  assign q_issue   = q_busy && (q_rem != '0);
  assign q_hit     = q_busy && q_pend && (rd_data[63:32] == q_key);
  assign q_miss    = q_busy && !q_hit && (q_rem == '0);

  always_comb begin
    rsp.full      = full;
    rsp.q_done    = q_hit || q_miss;
    rsp.q_found   = q_hit;
    rsp.q_greater = q_hit ? rd_data[31:0] : NONE_VALUE;
  end

  // Entries are read newest first; a read issued after a hit is simply ignored.
  always_ff @(posedge clk) begin
    if (req.wr_en && !full) begin
      tbl_mem[count[TAW-1:0]] <= {req.key, req.greater};
    end
    rd_data <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      count <= '0;
    end else if (req.wr_en && !full) begin
      count <= count + TCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_busy <= 1'b0;
      q_pend <= 1'b0;
      q_rem  <= '0;
    end else if (req.q_start) begin
      q_busy <= 1'b1;
      q_pend <= 1'b0;
      q_rem  <= count;
    end else if (q_busy) begin
      if (q_hit || q_miss) begin
        q_busy <= 1'b0;
        q_pend <= 1'b0;
      end else begin
        q_pend <= q_issue;
        if (q_issue) begin
          q_rem <= q_rem_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.q_start) begin
      q_key <= req.q_key;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= TCW'(TABLE_DEPTH))
    else $error("table fill count beyond depth");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.q_done |-> q_busy)
    else $error("search completion without an active search");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    q_busy |-> (q_rem <= count))
    else $error("search cursor past the filled part of the table");

endmodule

`default_nettype wire

// ----- rtl/core/next_greater_element_table_top.sv -----
// Top level of the next greater element table: control sequencer and stack memory.
// Depends on nget_pkg and instantiates nget_table.
//
// Usage. Input words (cmd, value) arrive on in_valid/in_stall; one result word
// (status, found, next_value) leaves on out_valid/out_stall for every input word.
// cmd 0 clears stack and table, cmd 1 loads one sequence element (elements are
// given last to first), cmd 2 looks a value up in the table, cmd 3 does nothing.
// The block works on one word at a time. A load passes through its accept
// step, one pop step per stack entry it pops, a step that records and pushes,
// and a result step; since every element is pushed at most once, pops average
// at most one per load. A query reads the table memory one entry per cycle
// from the newest entry back until it finds the key or runs out of entries;
// clear and the unused code go straight from accept to the result step.
// Each memory has a single read port, which is why the steps are split so.
// Reset (synchronous, active high) empties stack and table and drops any held
// result word. When the receiver stalls, the result word stays in the output
// register and the block still accepts and works on the next input word; it
// waits in its result step only when a second result is ready before the
// first has been taken.
`default_nettype none

module next_greater_element_table_top #(
  parameter int STACK_DEPTH = 256,
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic                    found,
  output logic signed [31:0]      next_value
);
  import nget_pkg::*;

  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);

  state_t state;
  state_t state_next;

  // Current input word.
  logic [1:0]  cur_cmd;
  logic [31:0] cur_value;

  // Stack memory; its read port always points at the top of the next cycle.
  logic [31:0]    stk_mem [STACK_DEPTH];
  logic [31:0]    stk_top;
  logic [SCW-1:0] stk_count;
  logic [SCW-1:0] stk_count_next;
  logic [SCW-1:0] stk_top_idx;
  logic [SAW-1:0] stk_rd_addr;

  logic accept;
  logic pop;
  logic push;
  logic record;
  logic stop;
  logic out_load;

  // Result held until the output register is free.
  logic [1:0]  res_status;
  logic        res_found;
  logic [31:0] res_next;
  logic [1:0]  res_status_next;

  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;

  nget_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .req(tbl_req),
    .rsp(tbl_rsp)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_RESULT) && (!out_valid || !out_stall);

  // Pop while the top is less than or equal to the element (signed compare).
  assign pop  = (state == S_POP) && (stk_count != '0)
                && ($signed(stk_top) <= $signed(cur_value));
  assign stop = (state == S_POP) && !pop;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_LOAD:  state_next = S_POP;
            CMD_QUERY: state_next = S_SEARCH;
            default:   state_next = S_RESULT;
          endcase
        end
      end
      S_POP: begin
        if (stop) begin
          state_next = S_RESULT;
        end
      end
      S_SEARCH: begin
        if (tbl_rsp.q_done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath control: stack moves, table requests and the load status.
  always_comb begin
    record          = stop && (stk_count != '0);
    push            = stop && (stk_count != SCW'(STACK_DEPTH));
    stk_count_next  = stk_count;
    res_status_next = ST_OK;
    if (accept && cmd == CMD_CLEAR) begin
      stk_count_next = '0;
    end else if (pop) begin
      stk_count_next = stk_count - SCW'(1);
    end else if (push) begin
      stk_count_next = stk_count + SCW'(1);
    end
    if (stop && !push) begin
      res_status_next = ST_STACK_FULL;
    end else if (record && tbl_rsp.full) begin
      res_status_next = ST_TABLE_FULL;
    end

    tbl_req.clear   = accept && (cmd == CMD_CLEAR);
    tbl_req.wr_en   = record;
    tbl_req.key     = cur_value;
    tbl_req.greater = stk_top;
    tbl_req.q_start = accept && (cmd == CMD_QUERY);
    tbl_req.q_key   = value;
  end

  assign stk_top_idx = stk_count_next - SCW'(1);
  assign stk_rd_addr = stk_top_idx[SAW-1:0];

  // A push writes the entry the read port points at in that same cycle; the
  // result step that always follows lets the port read the written entry anew.
  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[stk_count[SAW-1:0]] <= cur_value;
    end
    stk_top <= stk_mem[stk_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stk_count <= '0;
    end else begin
      state     <= state_next;
      stk_count <= stk_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd   <= cmd;
      cur_value <= value;
      res_status <= ST_OK;
      res_found  <= 1'b0;
      res_next   <= '0;
    end else if (stop) begin
      res_status <= res_status_next;
    end else if (state == S_SEARCH && tbl_rsp.q_done) begin
      res_found <= tbl_rsp.q_found;
      res_next  <= tbl_rsp.q_greater;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_status;
      found      <= res_found;
      next_value <= res_next;
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stk_count <= SCW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_query_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (cur_cmd == CMD_QUERY))
    else $error("table search entered for a word that is not a query");

  a_pop_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (cur_cmd == CMD_LOAD))
    else $error("stack pop entered for a word that is not a load");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");

endmodule

`default_nettype wire
